FILE: src/assert_macros.svh
// Assertion macros used by the top level of the page-run allocator.
// Defining SYNTH leaves every macro with an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/cpra_pkg.sv
// Shared types and constants of the contiguous page-run allocator.
// No dependencies; used by the controller, the datapath and the top level.
package cpra_pkg;

   // request stream layout (tdata, low bits first)
   localparam int BYTES_W  = 24;
   localparam int FRAMES_W = 32;
   localparam int ADDR_W   = 64;
   localparam int BYTES_LO  = 0;
   localparam int FRAMES_LO = BYTES_LO + BYTES_W;
   localparam int RADDR_LO  = FRAMES_LO + FRAMES_W;
   localparam int REQ_W     = 120;

   // result stream layout (tdata, low bits first)
   localparam int STATUS_W = 3;
   localparam int FIRST_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int RSP_W    = 104;

   // configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RESERVE = 1'b1;
   localparam logic [63:0] WINDOW_BASE_RESET   = 64'hFFFF_FFFF_8100_0000;
   localparam logic [15:0] FRAME_RESERVE_RESET = 16'd256;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_SIZE   = 3'd1,
      ST_NO_RUN     = 3'd2,
      ST_FRAMES_LOW = 3'd3,
      ST_OUTSIDE    = 3'd4,
      ST_NOT_START  = 3'd5,
      ST_NULL       = 3'd6
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear;        // reset-time RAM clearing write
      logic       load;         // capture request
      logic       scan_init;
      logic       scan;         // one page read/evaluated
      logic       commit_init;  // record run length, start marking
      logic       release_init; // clear run length, start releasing
      logic       step;         // one bitmap write of commit/release
      logic       addr_calc;
      logic       set_status;
      status_type status;
      logic       emit;         // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic bad_size;
      logic is_null;
      logic outside;
      logic hit;
      logic scan_done;
      logic frames_low;
      logic run_zero;
      logic step_last;
      logic out_busy;
   } stat_type;

endpackage

FILE: src/cpra_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cpra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/cpra_ctrl.sv
// Controller state machine of the page-run allocator.
// Depends on cpra_pkg (command and status structs, status codes).
module cpra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  cpra_pkg::stat_type stat,
   output cpra_pkg::cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_CLEAR      = 10'b00_0000_0001,
      S_IDLE       = 10'b00_0000_0010,
      S_DECODE     = 10'b00_0000_0100,
      S_SCAN       = 10'b00_0000_1000,
      S_CHECK      = 10'b00_0001_0000,
      S_COMMIT     = 10'b00_0010_0000,
      S_FREE_CHECK = 10'b00_0100_0000,
      S_RELEASE    = 10'b00_1000_0000,
      S_ADDR       = 10'b01_0000_0000,
      S_RESPOND    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_tready       = 1'b0;
      cmd.clear        = 1'b0;
      cmd.load         = 1'b0;
      cmd.scan_init    = 1'b0;
      cmd.scan         = 1'b0;
      cmd.commit_init  = 1'b0;
      cmd.release_init = 1'b0;
      cmd.step         = 1'b0;
      cmd.addr_calc    = 1'b0;
      cmd.set_status   = 1'b0;
      cmd.status       = cpra_pkg::ST_OK;
      cmd.emit         = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.is_free) begin
               if (stat.bad_size) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = cpra_pkg::ST_BAD_SIZE;
                  state_in       = S_RESPOND;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SCAN;
               end
            end else if (stat.is_null) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpra_pkg::ST_NULL;
               state_in       = S_RESPOND;
            end else if (stat.outside) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpra_pkg::ST_OUTSIDE;
               state_in       = S_RESPOND;
            end else begin
               // run-length read at the page index is under way
               state_in = S_FREE_CHECK;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               state_in = S_CHECK;
            end else if (stat.scan_done) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpra_pkg::ST_NO_RUN;
               state_in       = S_RESPOND;
            end
         end
         S_CHECK: begin
            if (stat.frames_low) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpra_pkg::ST_FRAMES_LOW;
               state_in       = S_RESPOND;
            end else begin
               cmd.commit_init = 1'b1;
               state_in        = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.step = 1'b1;
            if (stat.step_last) begin
               state_in = S_ADDR;
            end
         end
         S_FREE_CHECK: begin
            if (stat.run_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = cpra_pkg::ST_NOT_START;
               state_in       = S_RESPOND;
            end else begin
               cmd.release_init = 1'b1;
               state_in         = S_RELEASE;
            end
         end
         S_RELEASE: begin
            cmd.step = 1'b1;
            if (stat.step_last) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.addr_calc  = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = cpra_pkg::ST_OK;
            state_in       = S_RESPOND;
         end
         S_RESPOND: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

FILE: src/cpra_dp.sv
// Datapath of the page-run allocator: request registers, page bitmap and
// run-length RAMs, scan counters, config registers and result register.
// Depends on cpra_pkg and cpra_ram.
module cpra_dp #(
   parameter int WINDOW_PAGES = 1024,
   parameter int PAGE_BYTES   = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cpra_pkg::REQ_W-1:0]          req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_we,
   input  logic [cpra_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpra_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  cpra_pkg::cmd_type                   cmd,
   output cpra_pkg::stat_type                  stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cpra_pkg::RSP_W-1:0]          rsp_tdata
);

   localparam int PW = $clog2(WINDOW_PAGES);
   localparam int CW = $clog2(WINDOW_PAGES + 1);
   localparam int SH = $clog2(PAGE_BYTES);
   localparam int NW = cpra_pkg::BYTES_W + 1 - SH;
   localparam logic [63:0]   SPAN      = 64'(WINDOW_PAGES) * 64'(PAGE_BYTES);
   localparam logic [PW-1:0] LAST_PAGE = PW'(WINDOW_PAGES - 1);
   localparam int PAD_W = cpra_pkg::RSP_W - cpra_pkg::STATUS_W - cpra_pkg::ADDR_W
                          - cpra_pkg::FIRST_W - 2 * cpra_pkg::COUNT_W;

   // bitmap entry bits
   localparam int USED_BIT   = 0;
   localparam int BACKED_BIT = 1;

   logic [63:0]  window_base_ff;
   logic [15:0]  frame_reserve_ff;

   logic                 kind_ff;
   logic [31:0]          frames_ff;
   logic [NW-1:0]        need_ff;
   logic [63:0]          off_ff;
   logic                 borrow_ff;
   logic                 null_ff;

   logic [PW:0]          scan_addr_ff;
   logic                 dvalid_ff;
   logic [PW-1:0]        didx_ff;
   logic [PW-1:0]        start_ff;
   logic [CW-1:0]        run_ff;
   logic [CW-1:0]        want_ff;
   logic [PW-1:0]        ptr_ff;
   logic [CW-1:0]        left_ff;
   logic [PW-1:0]        clr_ff;

   logic [63:0]              addr_ff;
   cpra_pkg::status_type     status_ff;
   logic                     rsp_valid_ff;
   logic [cpra_pkg::RSP_W-1:0] rsp_data_ff;

   logic [1:0]    bm_rdata;
   logic [CW-1:0] rl_rdata;
   logic [PW-1:0] idx;
   logic [CW-1:0] run_inc;
   logic          issue;
   logic          page_free;

   logic [cpra_pkg::BYTES_W-1:0]  req_bytes;
   logic [cpra_pkg::FRAMES_W-1:0] req_frames;
   logic [cpra_pkg::ADDR_W-1:0]   req_addr;
   logic [cpra_pkg::BYTES_W:0]    bytes_round;
   logic [64:0]                   off_full;

   logic          bm_we;
   logic [PW-1:0] bm_waddr;
   logic [1:0]    bm_wdata;
   logic          rl_we;
   logic [PW-1:0] rl_waddr;
   logic [CW-1:0] rl_wdata;

   assign req_bytes  = req_tdata[cpra_pkg::BYTES_LO +: cpra_pkg::BYTES_W];
   assign req_frames = req_tdata[cpra_pkg::FRAMES_LO +: cpra_pkg::FRAMES_W];
   assign req_addr   = req_tdata[cpra_pkg::RADDR_LO +: cpra_pkg::ADDR_W];
   assign bytes_round = {1'b0, req_bytes} + (cpra_pkg::BYTES_W + 1)'(PAGE_BYTES - 1);
   assign off_full    = {1'b0, req_addr} - {1'b0, window_base_ff};

   assign idx       = off_ff[SH +: PW];
   assign run_inc   = run_ff + CW'(1);
   assign issue     = (scan_addr_ff < (PW + 1)'(WINDOW_PAGES));
   assign page_free = !bm_rdata[USED_BIT];

   // status to controller
   always_comb begin
      stat.clear_last = (clr_ff == LAST_PAGE);
      stat.is_free    = kind_ff;
      stat.bad_size   = (need_ff == '0) || (32'(need_ff) > 32'(WINDOW_PAGES));
      stat.is_null    = null_ff;
      stat.outside    = borrow_ff || (off_ff >= SPAN);
      stat.hit        = dvalid_ff && page_free && (32'(run_inc) == 32'(need_ff));
      stat.scan_done  = dvalid_ff && (didx_ff == LAST_PAGE) &&
                        !(page_free && (32'(run_inc) == 32'(need_ff)));
      stat.frames_low = (33'(want_ff) + 33'(frame_reserve_ff)) > 33'(frames_ff);
      stat.run_zero   = (rl_rdata == '0);
      stat.step_last  = (left_ff == CW'(1));
      stat.out_busy   = rsp_valid_ff && !rsp_tready;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff   <= cpra_pkg::WINDOW_BASE_RESET;
         frame_reserve_ff <= cpra_pkg::FRAME_RESERVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cpra_pkg::CSR_WINDOW_BASE:   window_base_ff   <= csr_wdata;
            cpra_pkg::CSR_FRAME_RESERVE: frame_reserve_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_tuser;
         frames_ff <= req_frames;
         need_ff   <= NW'(bytes_round >> SH);
         off_ff    <= off_full[63:0];
         borrow_ff <= off_full[64];
         null_ff   <= (req_addr == '0);
      end
   end

   // scan pipeline: read issued in a cycle, page evaluated in the next
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_addr_ff <= '0;
         dvalid_ff    <= 1'b0;
         run_ff       <= '0;
         want_ff      <= '0;
      end else if (cmd.scan) begin
         dvalid_ff <= issue;
         didx_ff   <= scan_addr_ff[PW-1:0];
         if (issue) begin
            scan_addr_ff <= scan_addr_ff + (PW + 1)'(1);
         end
         if (dvalid_ff) begin
            if (!page_free) begin
               run_ff <= '0;
            end else begin
               if (run_ff == '0) begin
                  start_ff <= didx_ff;
                  want_ff  <= CW'(!bm_rdata[BACKED_BIT]);
               end else begin
                  want_ff  <= want_ff + CW'(!bm_rdata[BACKED_BIT]);
               end
               run_ff <= run_inc;
            end
         end
      end else if (cmd.release_init) begin
         start_ff <= idx;
         run_ff   <= rl_rdata;
         want_ff  <= '0;
      end
   end

   // commit / release walker
   always_ff @(posedge clock) begin
      if (cmd.commit_init) begin
         ptr_ff  <= start_ff;
         left_ff <= run_ff;
      end else if (cmd.release_init) begin
         ptr_ff  <= idx;
         left_ff <= rl_rdata;
      end else if (cmd.step) begin
         ptr_ff  <= ptr_ff + PW'(1);
         left_ff <= left_ff - CW'(1);
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + PW'(1);
      end
   end

   // RAM write ports
   always_comb begin
      bm_we    = cmd.clear || cmd.step;
      bm_waddr = cmd.clear ? clr_ff : ptr_ff;
      bm_wdata = '0;
      if (!cmd.clear) begin
         // pages in a live run are always backed; free keeps the backing
         bm_wdata[BACKED_BIT] = 1'b1;
         bm_wdata[USED_BIT]   = !kind_ff;
      end
      rl_we    = cmd.clear || cmd.commit_init || cmd.release_init;
      rl_waddr = cmd.clear ? clr_ff : (cmd.commit_init ? start_ff : idx);
      rl_wdata = (!cmd.clear && cmd.commit_init) ? run_ff : '0;
   end

   cpra_ram #(
      .WIDTH (2),
      .DEPTH (WINDOW_PAGES)
   ) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (scan_addr_ff[PW-1:0]),
      .rdata (bm_rdata)
   );

   cpra_ram #(
      .WIDTH (CW),
      .DEPTH (WINDOW_PAGES)
   ) u_runlen (
      .clock (clock),
      .we    (rl_we),
      .waddr (rl_waddr),
      .wdata (rl_wdata),
      .raddr (idx),
      .rdata (rl_rdata)
   );

   // result assembly
   always_ff @(posedge clock) begin
      if (cmd.addr_calc) begin
         addr_ff <= window_base_ff + (64'(start_ff) << SH);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.emit) begin
         if (status_ff == cpra_pkg::ST_OK) begin
            rsp_data_ff <= {PAD_W'(0),
                            cpra_pkg::COUNT_W'(want_ff),
                            cpra_pkg::COUNT_W'(run_ff),
                            cpra_pkg::FIRST_W'(start_ff),
                            addr_ff,
                            status_ff};
         end else begin
            rsp_data_ff <= {(cpra_pkg::RSP_W - cpra_pkg::STATUS_W)'(0), status_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: src/contiguous_page_run_allocator_top.sv
// First-fit contiguous page-run allocator over a window of WINDOW_PAGES pages
// of PAGE_BYTES each (a power of two). After reset the block clears its page
// bitmap and run-length RAMs, one page a cycle, and takes no request meanwhile
// (configuration writes still land). One request is worked at a time. An
// allocate reads the bitmap one page per cycle from page 0 until the first
// fitting run ends, then writes one page per cycle to mark it; the bitmap RAM
// port bounds both passes. A no-run or frames-low refusal comes only after the
// scan. The result register lets the next request in while a result waits.
// Depends on cpra_pkg, cpra_ctrl, cpra_dp, cpra_ram and assert_macros.svh.
`include "assert_macros.svh"

module contiguous_page_run_allocator_top #(
   parameter int WINDOW_PAGES = 1024,
   parameter int PAGE_BYTES   = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata = request_bytes[23:0], free_frames[55:24],
   //                  release_address[119:56]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cpra_pkg::REQ_W-1:0]      req_tdata,
   // request: tuser = kind (0 allocate, 1 free)
   input  logic                            req_tuser,
   // result: tdata = status[2:0], run_address[66:3], first_page[76:67],
   //                 page_count[87:77], new_backing[98:88], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cpra_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_we,
   input  logic [cpra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cpra_pkg::CSR_DATA_W-1:0] csr_wdata
);

   cpra_pkg::cmd_type  cmd;
   cpra_pkg::stat_type stat;

   cpra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cpra_dp #(
      .WINDOW_PAGES (WINDOW_PAGES),
      .PAGE_BYTES   (PAGE_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // no request is taken during the clearing pass
   `ASSERT_IMPLIES(a_no_accept_in_clear, clock, reset, req_tready, !cmd.clear)
   // a result never overwrites one that is still waiting
   `ASSERT_IMPLIES(a_emit_when_free, clock, reset, cmd.emit, !stat.out_busy)
   // one request in flight at a time
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // failure results carry zero fields
   `ASSERT_IMPLIES(a_fail_zero, clock, reset,
      rsp_tvalid && (rsp_tdata[2:0] != cpra_pkg::ST_OK), rsp_tdata[98:3] == '0)

endmodule
